// File: hdl/mfd_pkg.sv
// Package for the MBAP frame decoder: beat types and status codes.
// No dependencies; used by the channel interfaces, the decoder and its checker.
package mfd_pkg;

   localparam int unsigned HeaderBytes = 8;
   localparam int unsigned MinLength   = 2;
   localparam int unsigned LengthBias  = 6;
   localparam int unsigned CountWidth  = 17;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_PROTO_ID   = 3'd2,
      STATUS_LEN_LOW    = 3'd3,
      STATUS_LEN_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        frame_done;
      logic [2:0]  status;
      logic [15:0] transaction_id;
      logic [7:0]  unit_id;
      logic [7:0]  function_code;
   } rsp_beat_type;

endpackage

// File: hdl/mfd_req_if.sv
// Byte input channel of the MBAP frame decoder: valid/ready plus one byte beat.
// Depends on mfd_pkg.
interface mfd_req_if;
   logic                  valid;
   logic                  ready;
   mfd_pkg::req_beat_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

// File: hdl/mfd_rsp_if.sv
// Result channel of the MBAP frame decoder: valid/ready plus one result beat.
// Depends on mfd_pkg.
interface mfd_rsp_if;
   logic                  valid;
   logic                  ready;
   mfd_pkg::rsp_beat_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

// File: hdl/mbap_frame_decoder.sv
// MBAP frame decoder top level: header capture, payload forwarding, status.
// Depends on mfd_pkg, mfd_req_if and mfd_rsp_if.
//
//   channel | dir | beat
//   --------+-----+-----------------------------------------------------------
//   req     | in  | data_byte, last_byte
//   rsp     | out | payload_valid/byte, frame_done, status, header fields
//
// One byte is accepted per cycle unless a held result stalls req; its result (if any) shows on rsp the next cycle.
// Header bytes that are not final give no result beat.
// The result register decouples the sides: req stays ready while a held
// result is being taken in the same cycle, and stalls only when it is not.
// Synchronous reset clears the counter, header registers and rsp valid.
module mbap_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   mfd_req_if.sink    req,
   mfd_rsp_if.source  rsp
);
   import mfd_pkg::*;

   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [15:0]           trans_id_ff, trans_id_in;
   logic [15:0]           proto_id_ff, proto_id_in;
   logic [15:0]           length_ff, length_in;
   logic [7:0]            unit_ff, unit_in;
   logic [7:0]            func_ff, func_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  payload;
   logic [CountWidth-1:0] total;
   status_type            status;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign payload   = byte_count_ff >= CountWidth'(HeaderBytes);
   assign total     = (&byte_count_ff) ? byte_count_ff : byte_count_ff + 1'b1;

   always_comb begin
      trans_id_in = trans_id_ff;
      proto_id_in = proto_id_ff;
      length_in   = length_ff;
      unit_in     = unit_ff;
      func_in     = func_ff;
      if (!payload) begin
         unique case (byte_count_ff[2:0])
            3'd0: trans_id_in[15:8] = req.data.data_byte;
            3'd1: trans_id_in[7:0]  = req.data.data_byte;
            3'd2: proto_id_in[15:8] = req.data.data_byte;
            3'd3: proto_id_in[7:0]  = req.data.data_byte;
            3'd4: length_in[15:8]   = req.data.data_byte;
            3'd5: length_in[7:0]    = req.data.data_byte;
            3'd6: unit_in           = req.data.data_byte;
            3'd7: func_in           = req.data.data_byte;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (total < CountWidth'(HeaderBytes)) begin
         status = STATUS_SHORT;
      end else if (proto_id_in != 16'd0) begin
         status = STATUS_PROTO_ID;
      end else if (length_in < 16'(MinLength)) begin
         status = STATUS_LEN_LOW;
      end else if (total != CountWidth'(LengthBias) + CountWidth'(length_in)) begin
         status = STATUS_LEN_MISMATCH;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.payload_valid  = payload;
      rsp_data_in.payload_byte   = payload ? req.data.data_byte : 8'd0;
      rsp_data_in.frame_done     = req.data.last_byte;
      if (req.data.last_byte) begin
         rsp_data_in.status         = status;
         rsp_data_in.transaction_id = trans_id_in;
         rsp_data_in.unit_id        = unit_in;
         rsp_data_in.function_code  = func_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && (payload || req.data.last_byte)) begin
         rsp_valid_in = 1'b1;
      end
      byte_count_in = byte_count_ff;
      if (accept) begin
         byte_count_in = req.data.last_byte ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         byte_count_ff <= '0;
         trans_id_ff   <= '0;
         proto_id_ff   <= '0;
         length_ff     <= '0;
         unit_ff       <= '0;
         func_ff       <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         byte_count_ff <= byte_count_in;
         if (accept) begin
            if (req.data.last_byte) begin
               trans_id_ff <= '0;
               proto_id_ff <= '0;
               length_ff   <= '0;
               unit_ff     <= '0;
               func_ff     <= '0;
            end else begin
               trans_id_ff <= trans_id_in;
               proto_id_ff <= proto_id_in;
               length_ff   <= length_in;
               unit_ff     <= unit_in;
               func_ff     <= func_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

// File: hdl/mfd_checker.sv
// Port-level checks for the MBAP frame decoder, bound to the top level.
// Depends on mfd_pkg and mbap_frame_decoder.
module mfd_port_checks (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_byte,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mfd_pkg::rsp_beat_type rsp_data
);
   import mfd_pkg::*;

   // a held result beat stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_beat_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.payload_valid || rsp_data.frame_done)
      else $error("rsp beat carries neither payload nor frame end");

   a_status_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |-> rsp_data.status == STATUS_OK)
      else $error("status set on a beat without frame end");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid && rsp_data.frame_done)
      else $error("final byte gave no frame end beat");

endmodule

bind mbap_frame_decoder mfd_port_checks u_mfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_byte (req.data.last_byte),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_data      (rsp.data)
);
